// ===== hdl/mme_pkg.sv =====
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types, command codes, message constants and the GM program tables
// of the MIDI message encoder.
// ----------------------------------------------------------------------------
package mme_pkg;

   localparam int IDX_W = 4;

   // command codes
   localparam logic [3:0] CMD_NOTE_OFF   = 4'd0;
   localparam logic [3:0] CMD_NOTE_ON    = 4'd1;
   localparam logic [3:0] CMD_POLY_AT    = 4'd2;
   localparam logic [3:0] CMD_CTRL       = 4'd3;
   localparam logic [3:0] CMD_PROGRAM    = 4'd4;
   localparam logic [3:0] CMD_CHAN_AT    = 4'd5;
   localparam logic [3:0] CMD_BEND       = 4'd6;
   localparam logic [3:0] CMD_GM_PROGRAM = 4'd7;
   localparam logic [3:0] CMD_VOLUME     = 4'd8;
   localparam logic [3:0] CMD_MASTER_VOL = 4'd9;
   localparam logic [3:0] CMD_ALL_OFF    = 4'd10;

   // status nibbles
   localparam logic [3:0] ST_NOTE_OFF = 4'h8;
   localparam logic [3:0] ST_NOTE_ON  = 4'h9;
   localparam logic [3:0] ST_POLY_AT  = 4'hA;
   localparam logic [3:0] ST_CTRL     = 4'hB;
   localparam logic [3:0] ST_PROGRAM  = 4'hC;
   localparam logic [3:0] ST_CHAN_AT  = 4'hD;
   localparam logic [3:0] ST_BEND     = 4'hE;

   // system exclusive and controller bytes
   localparam logic [7:0] SX_START    = 8'hF0;
   localparam logic [7:0] SX_END      = 8'hF7;
   localparam logic [7:0] SX_MAKER    = 8'h43;
   localparam logic [7:0] SX_NODE     = 8'h75;
   localparam logic [3:0] SX_DEV_HI   = 4'h1;
   localparam logic [7:0] SX_NODE_A   = 8'h10;
   localparam logic [7:0] SX_NODE_B   = 8'h24;
   localparam logic [7:0] SX_BANK_A   = 8'h15;
   localparam logic [7:0] SX_BANK_B   = 8'h04;
   localparam logic [7:0] CC_SUSTAIN  = 8'h40;
   localparam logic [7:0] CC_NOTES    = 8'h7B;
   localparam logic [7:0] CC_SOUND    = 8'h78;

   localparam logic [6:0] VOLUME_RESET = 7'd127;

   localparam logic [2:0] GM_BANK [128] = '{
      3'd5,3'd2,3'd2,3'd2,3'd2,3'd5,3'd2,3'd2, 3'd3,3'd3,3'd3,3'd2,3'd2,3'd4,3'd3,3'd5,
      3'd2,3'd2,3'd4,3'd5,3'd2,3'd2,3'd3,3'd5, 3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,
      3'd2,3'd2,3'd2,3'd4,3'd4,3'd6,3'd3,3'd3, 3'd4,3'd4,3'd4,3'd3,3'd5,3'd3,3'd3,3'd3,
      3'd2,3'd2,3'd5,3'd5,3'd5,3'd5,3'd5,3'd5, 3'd2,3'd2,3'd2,3'd3,3'd2,3'd5,3'd5,3'd5,
      3'd5,3'd5,3'd5,3'd5,3'd2,3'd4,3'd2,3'd2, 3'd3,3'd2,3'd3,3'd3,3'd5,3'd5,3'd5,3'd5,
      3'd2,3'd2,3'd3,3'd3,3'd3,3'd5,3'd4,3'd4, 3'd3,3'd2,3'd2,3'd5,3'd3,3'd6,3'd6,3'd6,
      3'd6,3'd6,3'd6,3'd3,3'd5,3'd6,3'd6,3'd5, 3'd4,3'd4,3'd4,3'd4,3'd5,3'd5,3'd4,3'd5,
      3'd4,3'd5,3'd3,3'd5,3'd5,3'd3,3'd5,3'd2, 3'd3,3'd3,3'd3,3'd5,3'd5,3'd2,3'd3,3'd3
   };

   localparam logic [5:0] GM_VOICE [128] = '{
      6'd0,6'd1,6'd2,6'd3,6'd4,6'd3,6'd13,6'd14, 6'd11,6'd13,6'd12,6'd16,6'd17,6'd11,6'd14,6'd12,
      6'd8,6'd9,6'd3,6'd6,6'd11,6'd12,6'd24,6'd9, 6'd19,6'd20,6'd21,6'd22,6'd23,6'd24,6'd24,6'd20,
      6'd36,6'd40,6'd41,6'd28,6'd27,6'd28,6'd36,6'd37, 6'd41,6'd42,6'd43,6'd34,6'd34,6'd35,6'd10,6'd15,
      6'd32,6'd33,6'd36,6'd37,6'd40,6'd38,6'd39,6'd41, 6'd26,6'd27,6'd28,6'd28,6'd25,6'd30,6'd31,6'd32,
      6'd24,6'd25,6'd26,6'd27,6'd22,6'd32,6'd24,6'd23, 6'd20,6'd21,6'd23,6'd22,6'd20,6'd21,6'd19,6'd20,
      6'd42,6'd43,6'd40,6'd41,6'd42,6'd38,6'd44,6'd45, 6'd45,6'd35,6'd44,6'd40,6'd46,6'd44,6'd43,6'd45,
      6'd42,6'd43,6'd44,6'd46,6'd44,6'd46,6'd47,6'd45, 6'd16,6'd17,6'd15,6'd14,6'd13,6'd23,6'd41,6'd21,
      6'd12,6'd15,6'd16,6'd16,6'd17,6'd19,6'd18,6'd19, 6'd47,6'd47,6'd47,6'd47,6'd46,6'd20,6'd47,6'd47
   };

   typedef struct packed {
      logic [3:0] cmd;
      logic [3:0] channel;
      logic [7:0] data1;
      logic [7:0] data2;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] midi_byte;
      logic       last_byte;
      logic [7:0] volume_readback;
   } rsp_payload_type;

   typedef struct packed {
      logic             fire;
      logic [IDX_W-1:0] idx;
      logic             last;
   } step_type;

   function automatic logic [IDX_W-1:0] msg_length(input logic [3:0] cmd,
                                                   input logic [7:0] data1);
      logic [IDX_W-1:0] len;
      case (cmd)
         CMD_NOTE_OFF, CMD_NOTE_ON, CMD_POLY_AT, CMD_CTRL, CMD_BEND: len = 4'd3;
         CMD_PROGRAM, CMD_CHAN_AT:                               len = 4'd2;
         CMD_GM_PROGRAM:                  len = data1[7] ? 4'd0 : 4'd9;
         CMD_VOLUME, CMD_MASTER_VOL:      len = 4'd8;
         CMD_ALL_OFF:                     len = 4'd9;
         default:                         len = 4'd0;
      endcase
      return len;
   endfunction

endpackage

// ===== hdl/midi_message_encoder.sv =====
// ----------------------------------------------------------------------------
// midi_message_encoder
// Turns one command item into its MIDI byte sequence, one byte per transfer.
// ----------------------------------------------------------------------------
//  channel  direction  ports
//  req      in         req_valid, req_ready, req_payload (cmd, channel, data1, data2)
//  rsp      out        rsp_valid, rsp_ready, rsp_payload (midi_byte, last_byte,
//                      volume_readback)
//  csr      in         csr_write_enable, csr_write_data (node_number)
//
//  an item is accepted, then the byte sequencer steps the shared byte unit
//  once per cycle through each message byte (0 to 9) while the output is free
//  req_ready is low while a message is being sent
//  the output register lets the next item be accepted while the final byte
//  waits; rsp_ready low holds the sequencer on the current byte
//  synchronous reset: node number 0, card volume 127, no message pending
// ----------------------------------------------------------------------------
module midi_message_encoder import mme_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_write_enable,
   input  logic [3:0]      csr_write_data
);

   req_payload_type  item_ff, item_in;
   logic [6:0]       volume_ff, volume_in;
   logic [3:0]       node_ff, node_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_payload_ff, rsp_payload_in;
   logic             req_fire;
   logic             out_free;
   step_type         step;
   logic [7:0]       byte_val;

   assign req_fire = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   mme_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req_len  (msg_length(req_payload.cmd, req_payload.data1)),
      .out_free (out_free),
      .ready    (req_ready),
      .step     (step)
   );

   mme_byte_unit u_byte (
      .item        (item_ff),
      .idx         (step.idx),
      .node_number (node_ff),
      .level       (volume_ff),
      .midi_byte   (byte_val)
   );

   always_comb begin
      item_in   = req_fire ? req_payload : item_ff;
      node_in   = csr_write_enable ? csr_write_data : node_ff;
      volume_in = volume_ff;
      if (req_fire && req_payload.cmd == CMD_VOLUME) begin
         volume_in = req_payload.data1[7:1];
      end else if (req_fire && req_payload.cmd == CMD_MASTER_VOL) begin
         volume_in = req_payload.data1[7] ? 7'd127 : req_payload.data1[6:0];
      end
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      if (step.fire) begin
         rsp_valid_in                   = 1'b1;
         rsp_payload_in.midi_byte       = byte_val;
         rsp_payload_in.last_byte       = step.last;
         rsp_payload_in.volume_readback = {volume_ff, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff    <= VOLUME_RESET;
         node_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         volume_ff    <= volume_in;
         node_ff      <= node_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== hdl/mme_seq.sv =====
// ----------------------------------------------------------------------------
// mme_seq
// Byte sequencer: walks the byte index of one message, one step per free
// output slot, and holds off new items until the message is done.
// ----------------------------------------------------------------------------
module mme_seq import mme_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_fire,
   input  logic [IDX_W-1:0] req_len,
   input  logic             out_free,
   output logic             ready,
   output step_type         step
);

   typedef enum logic [1:0] {
      SEQ_IDLE = 2'b01,
      SEQ_RUN  = 2'b10
   } seq_state_type;

   seq_state_type    state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] len_ff, len_in;
   logic             last;

   assign ready = (state_ff == SEQ_IDLE);
   assign last  = (idx_ff == len_ff - 4'd1);

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      len_in    = len_ff;
      step.fire = 1'b0;
      step.idx  = idx_ff;
      step.last = last;
      case (state_ff)
         SEQ_IDLE: begin
            if (req_fire && req_len != '0) begin
               state_in = SEQ_RUN;
               idx_in   = '0;
               len_in   = req_len;
            end
         end
         SEQ_RUN: begin
            if (out_free) begin
               step.fire = 1'b1;
               idx_in    = idx_ff + 4'd1;
               if (last) begin
                  state_in = SEQ_IDLE;
               end
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         idx_ff   <= '0;
         len_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         len_ff   <= len_in;
      end
   end

endmodule

// ===== hdl/mme_byte_unit.sv =====
// ----------------------------------------------------------------------------
// mme_byte_unit
// Shared byte generator: forms the message byte at a given index for the
// held command, including the GM bank and voice lookup.
// ----------------------------------------------------------------------------
module mme_byte_unit import mme_pkg::*; (
   input  req_payload_type  item,
   input  logic [IDX_W-1:0] idx,
   input  logic [3:0]       node_number,
   input  logic [6:0]       level,
   output logic [7:0]       midi_byte
);

   logic [7:0] key;
   logic [7:0] vel;
   logic [3:0] ch;
   logic [7:0] sx_dev;
   logic [7:0] ctrl_status;

   assign key         = {1'b0, item.data1[6:0]};
   assign vel         = {1'b0, item.data2[6:0]};
   assign ch          = item.channel;
   assign sx_dev      = {SX_DEV_HI, ch};
   assign ctrl_status = {ST_CTRL, ch};

   always_comb begin
      midi_byte = '0;
      case (item.cmd)
         CMD_NOTE_OFF, CMD_NOTE_ON, CMD_POLY_AT, CMD_CTRL, CMD_BEND: begin
            case (idx)
               4'd0: begin
                  case (item.cmd)
                     CMD_NOTE_OFF: midi_byte = {ST_NOTE_OFF, ch};
                     CMD_NOTE_ON:  midi_byte = (vel == '0) ? {ST_NOTE_OFF, ch}
                                                           : {ST_NOTE_ON, ch};
                     CMD_POLY_AT:  midi_byte = {ST_POLY_AT, ch};
                     CMD_CTRL:     midi_byte = ctrl_status;
                     default:      midi_byte = {ST_BEND, ch};
                  endcase
               end
               4'd1:    midi_byte = key;
               default: midi_byte = vel;
            endcase
         end
         CMD_PROGRAM, CMD_CHAN_AT: begin
            if (idx == '0) begin
               midi_byte = (item.cmd == CMD_PROGRAM) ? {ST_PROGRAM, ch} : {ST_CHAN_AT, ch};
            end else begin
               midi_byte = key;
            end
         end
         CMD_GM_PROGRAM: begin
            case (idx)
               4'd0:    midi_byte = SX_START;
               4'd1:    midi_byte = SX_MAKER;
               4'd2:    midi_byte = sx_dev;
               4'd3:    midi_byte = SX_BANK_A;
               4'd4:    midi_byte = SX_BANK_B;
               4'd5:    midi_byte = {5'd0, GM_BANK[item.data1[6:0]]};
               4'd6:    midi_byte = SX_END;
               4'd7:    midi_byte = {ST_PROGRAM, ch};
               default: midi_byte = {2'd0, GM_VOICE[item.data1[6:0]]};
            endcase
         end
         CMD_VOLUME, CMD_MASTER_VOL: begin
            case (idx)
               4'd0:    midi_byte = SX_START;
               4'd1:    midi_byte = SX_MAKER;
               4'd2:    midi_byte = SX_NODE;
               4'd3:    midi_byte = {4'd0, node_number};
               4'd4:    midi_byte = SX_NODE_A;
               4'd5:    midi_byte = SX_NODE_B;
               4'd6:    midi_byte = {1'b0, level};
               default: midi_byte = SX_END;
            endcase
         end
         CMD_ALL_OFF: begin
            case (idx)
               4'd0, 4'd3, 4'd6: midi_byte = ctrl_status;
               4'd1:             midi_byte = CC_SUSTAIN;
               4'd4:             midi_byte = CC_NOTES;
               4'd7:             midi_byte = CC_SOUND;
               default:          midi_byte = 8'h00;
            endcase
         end
         default: begin
            midi_byte = '0;
         end
      endcase
   end

endmodule

// ===== hdl/mme_checker.sv =====
// ----------------------------------------------------------------------------
// mme_checker
// Port-level checks on the MIDI message encoder, bound to the top level.
// ----------------------------------------------------------------------------
module mme_checker import mme_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input req_payload_type req_payload,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   // a stalled byte holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp byte changed while stalled");

   // no new item while a non-final byte is waiting
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last_byte |-> !req_ready)
      else $error("req_ready high in the middle of a message");

   // a note off transfer always blocks the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.cmd == CMD_NOTE_OFF |=> !req_ready)
      else $error("req_ready high right after a note off transfer");

   // readback is a doubled 7-bit level
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_payload.volume_readback[0])
      else $error("odd volume readback");

endmodule

bind midi_message_encoder mme_checker u_mme_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

// ===== test/mme_stream_checker.sv =====
// ----------------------------------------------------------------------------
// mme_stream_checker
// Watches the command and byte channels of the MIDI message encoder. Every
// accepted command is expanded into the byte sequence that the encoder must
// send. Each byte transfer is compared field by field with the oldest
// outstanding byte. The checker keeps its own node number and card volume.
// It reports the failure count and the number of outstanding bytes.
// ----------------------------------------------------------------------------
module mme_stream_checker import mme_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_payload,
   input  logic            csr_write_enable,
   input  logic [3:0]      csr_write_data,
   output int              failures,
   output int              pending
);

   localparam logic [3:0] STAT_NOTE_OFF = 4'h8;
   localparam logic [3:0] STAT_NOTE_ON  = 4'h9;
   localparam logic [3:0] STAT_POLY_AT  = 4'hA;
   localparam logic [3:0] STAT_CTRL     = 4'hB;
   localparam logic [3:0] STAT_PROGRAM  = 4'hC;
   localparam logic [3:0] STAT_CHAN_AT  = 4'hD;
   localparam logic [3:0] STAT_BEND     = 4'hE;
   localparam logic [3:0] SYX_DEVICE    = 4'h1;
   localparam logic [7:0] SYX_START     = 8'hF0;
   localparam logic [7:0] SYX_END       = 8'hF7;
   localparam logic [7:0] SYX_MAKER     = 8'h43;
   localparam logic [7:0] SYX_NODE      = 8'h75;
   localparam logic [7:0] SYX_NODE_CMD  = 8'h10;
   localparam logic [7:0] SYX_NODE_VOL  = 8'h24;
   localparam logic [7:0] SYX_BANK_CMD  = 8'h15;
   localparam logic [7:0] SYX_BANK_SEL  = 8'h04;
   localparam logic [7:0] CTL_SUSTAIN   = 8'h40;
   localparam logic [7:0] CTL_NOTES_OFF = 8'h7B;
   localparam logic [7:0] CTL_SOUND_OFF = 8'h78;
   localparam logic [6:0] LEVEL_AT_RESET = 7'd127;
   localparam int         REPORT_LIMIT  = 10;

   localparam logic [6:0] BANK_OF_PROGRAM [128] = '{
      5,2,2,2,2,5,2,2,3,3,3,2,2,4,3,5,
      2,2,4,5,2,2,3,5,4,4,4,4,4,4,4,4,
      2,2,2,4,4,6,3,3,4,4,4,3,5,3,3,3,
      2,2,5,5,5,5,5,5,2,2,2,3,2,5,5,5,
      5,5,5,5,2,4,2,2,3,2,3,3,5,5,5,5,
      2,2,3,3,3,5,4,4,3,2,2,5,3,6,6,6,
      6,6,6,3,5,6,6,5,4,4,4,4,5,5,4,5,
      4,5,3,5,5,3,5,2,3,3,3,5,5,2,3,3
   };

   localparam logic [6:0] VOICE_OF_PROGRAM [128] = '{
      0,1,2,3,4,3,13,14,11,13,12,16,17,11,14,12,
      8,9,3,6,11,12,24,9,19,20,21,22,23,24,24,20,
      36,40,41,28,27,28,36,37,41,42,43,34,34,35,10,15,
      32,33,36,37,40,38,39,41,26,27,28,28,25,30,31,32,
      24,25,26,27,22,32,24,23,20,21,23,22,20,21,19,20,
      42,43,40,41,42,38,44,45,45,35,44,40,46,44,43,45,
      42,43,44,46,44,46,47,45,16,17,15,14,13,23,41,21,
      12,15,16,16,17,19,18,19,47,47,47,47,46,20,47,47
   };

   rsp_payload_type expected_bytes [$];
   logic [3:0]      node_id;
   logic [6:0]      card_level;
   int              mismatch_total = 0;

   task automatic log_failure(input string what);
      mismatch_total++;
      if (mismatch_total <= REPORT_LIMIT) $display("%0t: %s", $time, what);
   endtask

   task automatic expand_command(input req_payload_type item);
      logic [7:0] msg [$];
      logic [7:0] key;
      logic [7:0] val;
      logic [7:0] program_no;
      logic [6:0] level;
      rsp_payload_type one;
      key = {1'b0, item.data1[6:0]};
      val = {1'b0, item.data2[6:0]};
      program_no = item.data1;
      case (item.cmd)
         CMD_NOTE_OFF: begin
            msg.push_back({STAT_NOTE_OFF, item.channel});
            msg.push_back(key);
            msg.push_back(val);
         end
         CMD_NOTE_ON: begin
            // zero velocity goes out as note off
            msg.push_back({(val == 8'h00) ? STAT_NOTE_OFF : STAT_NOTE_ON, item.channel});
            msg.push_back(key);
            msg.push_back(val);
         end
         CMD_POLY_AT: begin
            msg.push_back({STAT_POLY_AT, item.channel});
            msg.push_back(key);
            msg.push_back(val);
         end
         CMD_CTRL: begin
            msg.push_back({STAT_CTRL, item.channel});
            msg.push_back(key);
            msg.push_back(val);
         end
         CMD_PROGRAM: begin
            msg.push_back({STAT_PROGRAM, item.channel});
            msg.push_back(key);
         end
         CMD_CHAN_AT: begin
            msg.push_back({STAT_CHAN_AT, item.channel});
            msg.push_back(key);
         end
         CMD_BEND: begin
            msg.push_back({STAT_BEND, item.channel});
            msg.push_back(key);
            msg.push_back(val);
         end
         CMD_GM_PROGRAM: begin
            // programs above 127 send nothing
            if (program_no <= 8'd127) begin
               msg.push_back(SYX_START);
               msg.push_back(SYX_MAKER);
               msg.push_back({SYX_DEVICE, item.channel});
               msg.push_back(SYX_BANK_CMD);
               msg.push_back(SYX_BANK_SEL);
               msg.push_back({1'b0, BANK_OF_PROGRAM[program_no[6:0]]});
               msg.push_back(SYX_END);
               msg.push_back({STAT_PROGRAM, item.channel});
               msg.push_back({1'b0, VOICE_OF_PROGRAM[program_no[6:0]]});
            end
         end
         CMD_VOLUME, CMD_MASTER_VOL: begin
            if (item.cmd == CMD_VOLUME) level = item.data1[7:1];
            else level = item.data1[7] ? 7'd127 : item.data1[6:0];
            card_level = level;
            msg.push_back(SYX_START);
            msg.push_back(SYX_MAKER);
            msg.push_back(SYX_NODE);
            msg.push_back({4'h0, node_id});
            msg.push_back(SYX_NODE_CMD);
            msg.push_back(SYX_NODE_VOL);
            msg.push_back({1'b0, level});
            msg.push_back(SYX_END);
         end
         CMD_ALL_OFF: begin
            msg.push_back({STAT_CTRL, item.channel});
            msg.push_back(CTL_SUSTAIN);
            msg.push_back(8'h00);
            msg.push_back({STAT_CTRL, item.channel});
            msg.push_back(CTL_NOTES_OFF);
            msg.push_back(8'h00);
            msg.push_back({STAT_CTRL, item.channel});
            msg.push_back(CTL_SOUND_OFF);
            msg.push_back(8'h00);
         end
         default: ;
      endcase
      foreach (msg[i]) begin
         one.midi_byte       = msg[i];
         one.last_byte       = (i == msg.size() - 1);
         one.volume_readback = {card_level, 1'b0};
         expected_bytes.push_back(one);
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type due;
      if (reset) begin
         expected_bytes.delete();
         node_id    = 4'd0;
         card_level = LEVEL_AT_RESET;
      end else begin
         if (csr_write_enable) node_id = csr_write_data;
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               log_failure($sformatf("unexpected byte transfer %02h last %0b vol %02h",
                  rsp_payload.midi_byte, rsp_payload.last_byte,
                  rsp_payload.volume_readback));
            end else begin
               due = expected_bytes.pop_front();
               if (rsp_payload.midi_byte !== due.midi_byte ||
                   rsp_payload.last_byte !== due.last_byte ||
                   rsp_payload.volume_readback !== due.volume_readback) begin
                  log_failure($sformatf(
                     "byte mismatch: expected %02h last %0b vol %02h, got %02h last %0b vol %02h",
                     due.midi_byte, due.last_byte, due.volume_readback,
                     rsp_payload.midi_byte, rsp_payload.last_byte,
                     rsp_payload.volume_readback));
               end
            end
         end
         if (req_valid && req_ready) expand_command(req_payload);
      end
      failures <= mismatch_total;
      pending  <= expected_bytes.size();
   end

endmodule

// ===== test/tb_midi_message_encoder.sv =====
// ----------------------------------------------------------------------------
// tb_midi_message_encoder
// Drives command transfers into the MIDI message encoder: a directed set of
// field extremes and special cases, then random commands over several node
// numbers, with bursty input and a stalling byte receiver. The checker
// beside the block predicts and compares every byte; the top gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_midi_message_encoder;
   import mme_pkg::*;

   localparam logic [3:0] CMD_UNUSED_LO   = 4'd11;
   localparam logic [3:0] CMD_UNUSED_HI   = 4'd15;
   localparam int         DRAIN_CYCLES    = 16;
   localparam int         ITEMS_PER_PHASE = 96;
   localparam int         RUN_LIMIT       = 10_000_000;

   typedef enum logic [1:0] {READY_ALWAYS, READY_MOSTLY, READY_RARELY, READY_MASK}
      stall_mode_type;

   logic            clock            = 1'b0;
   logic            reset            = 1'b1;
   logic            req_valid        = 1'b0;
   logic            req_ready;
   req_payload_type req_payload      = '0;
   logic            rsp_valid;
   logic            rsp_ready        = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_write_enable = 1'b0;
   logic [3:0]      csr_write_data   = 4'd0;
   int              failures;
   int              pending;

   stall_mode_type  stall_mode = READY_ALWAYS;
   int              stall_left = 0;
   logic [7:0]      stall_mask = 8'hFF;
   int              burst_left = 0;

   always #5 clock = ~clock;

   midi_message_encoder i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   mme_stream_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .failures         (failures),
      .pending          (pending)
   );

   // receiver stalls in stretches of changing character
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_mask <= 8'($urandom_range(1, 255));
         stall_left <= $urandom_range(16, 96);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
         READY_RARELY: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:      rsp_ready <= stall_mask[stall_left % 8];
      endcase
   end

   function automatic req_payload_type command(input logic [3:0] cmd,
                                               input logic [3:0] channel,
                                               input logic [7:0] data1,
                                               input logic [7:0] data2);
      req_payload_type c;
      c.cmd     = cmd;
      c.channel = channel;
      c.data1   = data1;
      c.data2   = data2;
      return c;
   endfunction

   task automatic send_command(input req_payload_type item);
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 8);
      end else begin
         burst_left--;
      end
   endtask

   // only while idle: outstanding bytes drained and the sequencer settled
   task automatic write_node(input logic [3:0] node);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= node;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      #(RUN_LIMIT);
      $display("tb_midi_message_encoder: errors");
      $finish;
   end

   initial begin
      req_payload_type item;
      logic [3:0]      node_plan [4];
      int              produced;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      write_node(4'd15);
      send_command(command(CMD_NOTE_OFF,   4'd0,  8'h00, 8'h00));
      send_command(command(CMD_NOTE_OFF,   4'd15, 8'hFF, 8'hFF));
      send_command(command(CMD_NOTE_ON,    4'd3,  8'h3C, 8'h00));
      send_command(command(CMD_NOTE_ON,    4'd5,  8'h81, 8'h80));
      send_command(command(CMD_NOTE_ON,    4'd15, 8'h7F, 8'h7F));
      send_command(command(CMD_NOTE_ON,    4'd0,  8'h00, 8'h01));
      send_command(command(CMD_POLY_AT,    4'd7,  8'h40, 8'hFF));
      send_command(command(CMD_CTRL,       4'd10, 8'h07, 8'h64));
      send_command(command(CMD_PROGRAM,    4'd15, 8'hFF, 8'h00));
      send_command(command(CMD_PROGRAM,    4'd0,  8'h00, 8'hFF));
      send_command(command(CMD_CHAN_AT,    4'd2,  8'h7F, 8'h55));
      send_command(command(CMD_BEND,       4'd9,  8'h00, 8'h40));
      send_command(command(CMD_BEND,       4'd12, 8'hFF, 8'hFF));
      send_command(command(CMD_GM_PROGRAM, 4'd0,  8'h00, 8'h00));
      send_command(command(CMD_GM_PROGRAM, 4'd15, 8'h7F, 8'hFF));
      send_command(command(CMD_GM_PROGRAM, 4'd4,  8'h80, 8'h00));
      send_command(command(CMD_GM_PROGRAM, 4'd8,  8'hFF, 8'h00));
      send_command(command(CMD_VOLUME,     4'd0,  8'h00, 8'h00));
      send_command(command(CMD_VOLUME,     4'd6,  8'hFF, 8'hFF));
      send_command(command(CMD_VOLUME,     4'd1,  8'h01, 8'h00));
      send_command(command(CMD_MASTER_VOL, 4'd0,  8'hFF, 8'h00));
      send_command(command(CMD_MASTER_VOL, 4'd0,  8'h80, 8'h00));
      send_command(command(CMD_MASTER_VOL, 4'd0,  8'h00, 8'h00));
      send_command(command(CMD_MASTER_VOL, 4'd11, 8'h7F, 8'h7F));
      send_command(command(CMD_ALL_OFF,    4'd0,  8'h00, 8'h00));
      send_command(command(CMD_ALL_OFF,    4'd15, 8'hFF, 8'hFF));
      send_command(command(CMD_UNUSED_LO,  4'd3,  8'h12, 8'h34));
      send_command(command(CMD_UNUSED_HI,  4'd15, 8'hFF, 8'hFF));

      node_plan[0] = 4'd0;
      node_plan[1] = 4'($urandom_range(1, 14));
      node_plan[2] = 4'd15;
      node_plan[3] = 4'($urandom_range(0, 15));
      foreach (node_plan[p]) begin
         write_node(node_plan[p]);
         produced = 0;
         while (produced < ITEMS_PER_PHASE) begin
            item.channel = 4'($urandom_range(0, 15));
            item.data1   = 8'($urandom_range(0, 255));
            item.data2   = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < 5)
               item.cmd = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
            else
               item.cmd = 4'($urandom_range(CMD_NOTE_OFF, CMD_ALL_OFF));
            if ($urandom_range(0, 7) == 0) begin
               case ($urandom_range(0, 3))
                  0:       item.data1 = 8'h00;
                  1:       item.data1 = 8'h7F;
                  2:       item.data1 = 8'h80;
                  default: item.data1 = 8'hFF;
               endcase
            end
            if (item.cmd == CMD_GM_PROGRAM && $urandom_range(0, 7) != 0)
               item.data1[7] = 1'b0;
            if (item.cmd == CMD_NOTE_ON && $urandom_range(0, 7) == 0)
               item.data2[6:0] = 7'd0;
            send_command(item);
            produced++;
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && pending == 0)
         $display("tb_midi_message_encoder: clean");
      else
         $display("tb_midi_message_encoder: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/mme_pkg.sv
hdl/mme_seq.sv
hdl/mme_byte_unit.sv
hdl/midi_message_encoder.sv
hdl/mme_checker.sv
test/mme_stream_checker.sv
test/tb_midi_message_encoder.sv
